[rtl/tgad_pkg.sv]
// Shared types and constants for the TGA run-length image decoder.
// Depends on nothing; every other file of the block but tgad_if imports it.
package tgad_pkg;

  // Result status codes.
  localparam logic [1:0] ST_PIXEL       = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_INVALID     = 2'd2;

  // Header layout: fixed part, image type byte, size and depth fields.
  localparam logic [4:0] HDR_FIXED_LEN = 5'd12;
  localparam logic [4:0] HDR_TYPE_IDX  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;

  // Image type codes and supported pixel depths.
  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // One decoded result as it waits in the queue; color bytes stay in file order.
  typedef struct packed {
    logic [23:0] bgr;
    logic [7:0]  alpha;
    logic [7:0]  repeat_cnt;
    logic        last;
    logic [1:0]  status;
  } tgad_cmd_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } tgad_qstat_t;

endpackage

[rtl/tgad_if.sv]
// Channel interfaces of the TGA run-length image decoder: file bytes in, pixels out.
// Depends on nothing.
interface tgad_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface tgad_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_res;
  logic       last_pixel;
  logic [1:0] status;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_res, output last_pixel, output status, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_res, input last_pixel, input status, output ready);
endinterface

[rtl/tgad_front.sv]
// Front end: accepts file bytes, parses header and packets, assembles pixels.
// Depends on tgad_pkg and tgad_byte_if; pushes finished results into the queue.
module tgad_front (
  input  logic                 clk,
  input  logic                 rst_n,
  tgad_byte_if.sink            in_if,
  input  tgad_pkg::tgad_qstat_t q_stat,
  output logic                 push,
  output tgad_pkg::tgad_cmd_t  cmd
);
  import tgad_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PACKET = 2'd1;
  localparam logic [1:0] PH_PIXEL  = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [4:0]  hdr_idx_r, hdr_idx_nxt;
  logic        coded_r, coded_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        four_r, four_nxt;
  logic [31:0] pix_left_r, pix_left_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic        pkt_run_r, pkt_run_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [23:0] pix_bytes_r, pix_bytes_nxt;
  logic [31:0] area_r;

  logic        accept;
  logic [7:0]  b;
  logic [1:0]  ph_e;
  logic [4:0]  idx_e;
  logic [23:0] asm_bytes;
  logic [7:0]  alpha_v;
  logic [1:0]  need;
  logic [7:0]  rep;

  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;
  assign b           = in_if.data_byte;

  // A start-of-file byte restarts the parser at header byte zero.
  assign ph_e  = in_if.file_start ? PH_HEADER : phase_r;
  assign idx_e = in_if.file_start ? 5'd0 : hdr_idx_r;
  assign need  = four_r ? 2'd0 : 2'd3;

  // Parser next state and result generation.
  always_comb begin
    phase_nxt     = ph_e;
    hdr_idx_nxt   = idx_e;
    coded_nxt     = coded_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    four_nxt      = four_r;
    pix_left_nxt  = pix_left_r;
    pkt_left_nxt  = pkt_left_r;
    pkt_run_nxt   = pkt_run_r;
    bip_nxt       = bip_r;
    pix_bytes_nxt = pix_bytes_r;
    asm_bytes     = pix_bytes_r;
    alpha_v       = 8'd0;
    rep           = 8'd1;
    push          = 1'b0;
    cmd           = '0;
    unique case (ph_e)
      PH_HEADER: begin
        hdr_idx_nxt = idx_e + 5'd1;
        if (idx_e < HDR_FIXED_LEN) begin
          if (idx_e == HDR_TYPE_IDX) begin
            if (b == TYPE_RAW) begin
              coded_nxt = 1'b0;
            end else if (b == TYPE_RLE) begin
              coded_nxt = 1'b1;
            end else begin
              push       = 1'b1;
              cmd.status = ST_UNSUPPORTED;
            end
          end else if (b != 8'd0) begin
            push       = 1'b1;
            cmd.status = ST_UNSUPPORTED;
          end
        end else if (idx_e == HDR_WIDTH_LO) begin
          width_nxt = {8'd0, b};
        end else if (idx_e == HDR_WIDTH_HI) begin
          width_nxt = {b, width_r[7:0]};
        end else if (idx_e == HDR_HEIGHT_LO) begin
          height_nxt = {8'd0, b};
        end else if (idx_e == HDR_HEIGHT_HI) begin
          height_nxt = {b, height_r[7:0]};
        end else if (idx_e == HDR_DEPTH) begin
          if (width_r == 16'd0 || height_r == 16'd0 || (b != DEPTH_24 && b != DEPTH_32)) begin
            push       = 1'b1;
            cmd.status = ST_INVALID;
          end
          four_nxt = (b == DEPTH_32);
        end else begin
          // Descriptor byte: header done, pixel data follows.
          pix_left_nxt  = area_r;
          pkt_left_nxt  = 8'd0;
          pkt_run_nxt   = 1'b0;
          bip_nxt       = 2'd0;
          pix_bytes_nxt = 24'd0;
          phase_nxt     = coded_r ? PH_PACKET : PH_PIXEL;
        end
        if (push) begin
          phase_nxt   = PH_IDLE;
          hdr_idx_nxt = idx_e;
        end
      end
      PH_PACKET: begin
        // Raw and run packets both carry a count of the low seven bits plus one.
        pkt_run_nxt   = b[7];
        pkt_left_nxt  = {1'b0, b[6:0]} + 8'd1;
        bip_nxt       = 2'd0;
        pix_bytes_nxt = 24'd0;
        phase_nxt     = PH_PIXEL;
      end
      PH_PIXEL: begin
        unique case (bip_r)
          2'd0: asm_bytes = {pix_bytes_r[23:8], b};
          2'd1: asm_bytes = {pix_bytes_r[23:16], b, pix_bytes_r[7:0]};
          2'd2: asm_bytes = {b, pix_bytes_r[15:0]};
          default: alpha_v = b;
        endcase
        bip_nxt       = bip_r + 2'd1;
        pix_bytes_nxt = asm_bytes;
        if (bip_nxt == need) begin
          bip_nxt       = 2'd0;
          pix_bytes_nxt = 24'd0;
          if (coded_r && pkt_run_r) begin
            rep          = ({24'd0, pkt_left_r} > pix_left_r) ? pix_left_r[7:0] : pkt_left_r;
            pkt_left_nxt = 8'd0;
          end else if (coded_r && pkt_left_r != 8'd0) begin
            pkt_left_nxt = pkt_left_r - 8'd1;
          end
          pix_left_nxt   = pix_left_r - {24'd0, rep};
          push           = 1'b1;
          cmd.bgr        = asm_bytes;
          cmd.alpha      = alpha_v;
          cmd.repeat_cnt = rep;
          cmd.last       = (pix_left_nxt == 32'd0);
          cmd.status     = ST_PIXEL;
          if (pix_left_nxt == 32'd0) begin
            phase_nxt = PH_IDLE;
          end else if (coded_r && pkt_left_nxt == 8'd0) begin
            phase_nxt = PH_PACKET;
          end else begin
            phase_nxt = PH_PIXEL;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (!accept) begin
      push = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_idx_r <= 5'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
    end
  end

  // Image and packet registers; the pixel count product is kept ready each cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      coded_r     <= coded_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      four_r      <= four_nxt;
      pix_left_r  <= pix_left_nxt;
      pkt_left_r  <= pkt_left_nxt;
      pkt_run_r   <= pkt_run_nxt;
      bip_r       <= bip_nxt;
      pix_bytes_r <= pix_bytes_nxt;
    end
    area_r <= {16'd0, width_r} * {16'd0, height_r};
  end

endmodule

[rtl/tgad_queue.sv]
// Short result queue between the parser front end and the output stage.
// Depends on tgad_pkg.
module tgad_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tgad_pkg::tgad_cmd_t   push_cmd,
  input  logic                  pop,
  output tgad_pkg::tgad_cmd_t   head,
  output tgad_pkg::tgad_qstat_t stat
);
  import tgad_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tgad_cmd_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign head       = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/tgad_back.sv]
// Back end: takes queued results, reorders color bytes to RGB and holds the output register.
// Depends on tgad_pkg and tgad_pix_if.
module tgad_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tgad_pkg::tgad_cmd_t   head,
  input  tgad_pkg::tgad_qstat_t q_stat,
  output logic                  pop,
  tgad_pix_if.source            out_if
);
  import tgad_pkg::*;

  logic       valid_r;
  logic [7:0] red_r, green_r, blue_r, alpha_r, rep_r;
  logic       last_r;
  logic [1:0] status_r;

  // Load a new result whenever the output register is empty or being taken.
  assign pop = !q_stat.empty && (!valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_if.ready) begin
      valid_r <= !q_stat.empty;
    end
  end

  // File order is blue, green, red; the output is red, green, blue.
  always_ff @(posedge clk) begin
    if (pop) begin
      red_r    <= head.bgr[23:16];
      green_r  <= head.bgr[15:8];
      blue_r   <= head.bgr[7:0];
      alpha_r  <= head.alpha;
      rep_r    <= head.repeat_cnt;
      last_r   <= head.last;
      status_r <= head.status;
    end
  end

  assign out_if.valid      = valid_r;
  assign out_if.red        = red_r;
  assign out_if.green      = green_r;
  assign out_if.blue       = blue_r;
  assign out_if.alpha      = alpha_r;
  assign out_if.repeat_res = rep_r;
  assign out_if.last_pixel = last_r;
  assign out_if.status     = status_r;

endmodule

[rtl/tga_rle_image_decoder.sv]
// Top level of the TGA run-length image decoder: front end, result queue, back end.
// Depends on tgad_pkg, tgad_if, tgad_front, tgad_queue and tgad_back.
//
//   channel  direction  carries
//   in_if    sink       data_byte, file_start (one file byte per request)
//   out_if   source     red, green, blue, alpha, repeat_res, last_pixel, status
//
// One byte is accepted per cycle while in_if.ready is high; the per-byte parser
// update in the front end sets that rate. Results are queued, then registered.
// Reset (rst_n low at a clock edge) returns the parser to header byte zero and
// empties the queue. in_if.ready drops only while the QUEUE_DEPTH-entry queue is
// full, which happens when out_if stalls; both sides otherwise stall independently.
module tga_rle_image_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  tgad_byte_if.sink  in_if,
  tgad_pix_if.source out_if
);
  import tgad_pkg::*;

  logic        q_push;
  logic        q_pop;
  tgad_cmd_t   q_in;
  tgad_cmd_t   q_head;
  tgad_qstat_t q_stat;

  tgad_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_stat (q_stat),
    .push   (q_push),
    .cmd    (q_in)
  );

  tgad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  tgad_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_if (out_if)
  );

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("result written into a full queue");

  // The back end never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("result taken from an empty queue");

  // Error results carry no repeat count and never end the image.
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_PIXEL) |->
      (out_if.repeat_res == 8'd0 && !out_if.last_pixel))
    else $error("error result with pixel fields set");

  // A pixel result always repeats at least once.
  a_pixel_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status == ST_PIXEL) |-> out_if.repeat_res != 8'd0)
    else $error("pixel result with zero repeat count");

endmodule

[tb/tga_rle_image_decoder_check.sv]
// Watches both channels of the TGA decoder, predicts each pixel result and compares.
// Depends on tgad_pkg for status codes and header layout, and on tgad_if for the channels.
`timescale 1ns / 1ps

module tga_rle_image_decoder_check (
  input  logic  clk,
  input  logic  rst_n,
  tgad_byte_if  in_if,
  tgad_pix_if   out_if,
  output int    fail_count,
  output int    outstanding
);
  import tgad_pkg::*;

  // A packet header at or above this value is a run; its count is the header minus the bias.
  localparam logic [7:0] RUN_FLAG = 8'h80;
  localparam logic [7:0] RUN_BIAS = 8'd127;

  typedef enum logic [1:0] {
    DEC_HEADER,
    DEC_PACKET,
    DEC_PIXELS,
    DEC_DONE
  } dec_phase_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] rep;
    logic       last;
    logic [1:0] status;
  } pixel_res_t;

  // Parser state as the decoder should hold it.
  dec_phase_t  dec_phase;
  logic [4:0]  hdr_idx;
  logic        coded;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        has_alpha;
  logic [31:0] pix_left;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [1:0]  byte_pos;
  logic [23:0] bgr_acc;

  pixel_res_t pending_pixels[$];

  function automatic void clear_parser();
    dec_phase = DEC_HEADER;
    hdr_idx   = '0;
    coded     = 1'b0;
    img_w     = '0;
    img_h     = '0;
    has_alpha = 1'b0;
    pix_left  = '0;
    pkt_left  = '0;
    pkt_run   = 1'b0;
    byte_pos  = '0;
    bgr_acc   = '0;
  endfunction

  // Advances the parser by one file byte; returns 1 when the byte completes a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output pixel_res_t res);
    logic       bad;
    logic [1:0] bad_st;
    logic [7:0] alpha_b;
    logic [7:0] rep;
    res     = '0;
    bad     = 1'b0;
    bad_st  = ST_PIXEL;
    alpha_b = '0;
    rep     = '0;
    if (start) clear_parser();
    case (dec_phase)
      DEC_HEADER: begin
        if (hdr_idx < HDR_FIXED_LEN) begin
          if (hdr_idx == HDR_TYPE_IDX) begin
            if (b == TYPE_RAW || b == TYPE_RLE) coded = (b == TYPE_RLE);
            else bad = 1'b1;
          end else if (b != 8'h00) begin
            bad = 1'b1;
          end
          bad_st = ST_UNSUPPORTED;
        end else if (hdr_idx == HDR_WIDTH_LO) begin
          img_w = {8'h00, b};
        end else if (hdr_idx == HDR_WIDTH_HI) begin
          img_w[15:8] = b;
        end else if (hdr_idx == HDR_HEIGHT_LO) begin
          img_h = {8'h00, b};
        end else if (hdr_idx == HDR_HEIGHT_HI) begin
          img_h[15:8] = b;
        end else if (hdr_idx == HDR_DEPTH) begin
          // Size and depth are judged together once the depth byte is known.
          bad       = (img_w == '0) || (img_h == '0) || (b != DEPTH_24 && b != DEPTH_32);
          bad_st    = ST_INVALID;
          has_alpha = (b == DEPTH_32);
        end else begin
          // The descriptor byte is dropped; pixel data starts after it.
          pix_left  = 32'(img_w) * 32'(img_h);
          pkt_left  = '0;
          pkt_run   = 1'b0;
          byte_pos  = '0;
          bgr_acc   = '0;
          dec_phase = coded ? DEC_PACKET : DEC_PIXELS;
        end
        if (bad) begin
          dec_phase  = DEC_DONE;
          res.status = bad_st;
          return 1'b1;
        end
        hdr_idx = hdr_idx + 5'd1;
        return 1'b0;
      end
      DEC_PACKET: begin
        pkt_run   = (b >= RUN_FLAG);
        pkt_left  = pkt_run ? b - RUN_BIAS : b + 8'd1;
        byte_pos  = '0;
        bgr_acc   = '0;
        dec_phase = DEC_PIXELS;
        return 1'b0;
      end
      DEC_PIXELS: begin
        if (byte_pos < 2'd3) bgr_acc[8*byte_pos +: 8] = b;
        else alpha_b = b;
        if (byte_pos != (has_alpha ? 2'd3 : 2'd2)) begin
          byte_pos = byte_pos + 2'd1;
          return 1'b0;
        end
        byte_pos = '0;
        // A run that reaches past the image end is cut to the pixels that remain.
        if (coded && pkt_run) begin
          rep      = (32'(pkt_left) > pix_left) ? pix_left[7:0] : pkt_left;
          pkt_left = '0;
        end else begin
          rep = 8'd1;
          if (coded && pkt_left != '0) pkt_left = pkt_left - 8'd1;
        end
        pix_left = pix_left - 32'(rep);
        res = '{bgr_acc[23:16], bgr_acc[15:8], bgr_acc[7:0], alpha_b, rep,
                (pix_left == 32'd0), ST_PIXEL};
        bgr_acc = '0;
        if (pix_left == 32'd0) dec_phase = DEC_DONE;
        else if (coded && pkt_left == '0) dec_phase = DEC_PACKET;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Predict on every accepted request and compare every accepted result.
  always @(posedge clk) begin : watch
    pixel_res_t pred;
    pixel_res_t got;
    pixel_res_t want;
    if (!rst_n) begin
      clear_parser();
      pending_pixels.delete();
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (decode_byte(in_if.data_byte, in_if.file_start, pred))
          pending_pixels.push_back(pred);
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.red, out_if.green, out_if.blue, out_if.alpha, out_if.repeat_res,
                out_if.last_pixel, out_if.status};
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          compare_field("red", want.red, got.red);
          compare_field("green", want.green, got.green);
          compare_field("blue", want.blue, got.blue);
          compare_field("alpha", want.alpha, got.alpha);
          compare_field("repeat_res", want.rep, got.rep);
          compare_field("last_pixel", 8'(want.last), 8'(got.last));
          compare_field("status", 8'(want.status), 8'(got.status));
        end
      end
    end
    outstanding = pending_pixels.size();
  end

endmodule

[tb/tga_rle_image_decoder_tb.sv]
// Top of the TGA decoder testbench: clock, reset, file byte stimulus and result stalls.
// Depends on tgad_pkg, tgad_if, the decoder and tga_rle_image_decoder_check.
`timescale 1ns / 1ps

module tga_rle_image_decoder_tb;
  import tgad_pkg::*;

  localparam int         CLK_PERIOD      = 4;
  localparam int         RESET_CYCLES    = 11;
  localparam int         RANDOM_BYTES    = 1350;
  localparam int         HOLD_OFF_CYCLES = 80;
  localparam int         DRAIN_CYCLES    = 20;
  localparam int         TIMEOUT_NS      = 2_000_000;
  localparam logic [7:0] RUN_FLAG        = 8'h80;
  localparam int         RUN_BIAS        = 127;
  localparam int         MAX_PACKET      = 128;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   burst_left = 0;
  int   bytes_sent = 0;
  bit   hold_off = 1'b0;
  logic [7:0] file_q[$];

  tgad_byte_if in_if ();
  tgad_pix_if  out_if ();

  tga_rle_image_decoder DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  tga_rle_image_decoder_check pixel_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one byte, usually idling between bursts, and return on the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.file_start <= start;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic put_byte(input logic [7:0] b);
    file_q.push_back(b);
  endtask

  task automatic put_pixels(input int n, input bit four);
    repeat (n) repeat (four ? 4 : 3) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_header(input logic [7:0] img_type, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] depth);
    for (int i = 0; i < HDR_FIXED_LEN; i++) put_byte((i == HDR_TYPE_IDX) ? img_type : 8'h00);
    put_byte(w[7:0]);
    put_byte(w[15:8]);
    put_byte(h[7:0]);
    put_byte(h[15:8]);
    put_byte(depth);
    put_byte(8'($urandom_range(0, 255)));
  endtask

  // Packets of random kind and length; the last one may reach past the image end.
  task automatic put_rle_body(input longint total, input bit four, input int packets,
                              input int max_raw);
    longint left;
    int     cnt;
    left = total;
    while (left > 0 && packets > 0) begin
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0:       cnt = MAX_PACKET;
          1:       cnt = $urandom_range(1, MAX_PACKET);
          default: cnt = $urandom_range(1, 4);
        endcase
        put_byte(8'(cnt + RUN_BIAS));
        put_pixels(1, four);
      end else begin
        cnt = $urandom_range(1, max_raw);
        put_byte(8'(cnt - 1));
        put_pixels(cnt, four);
      end
      left -= cnt;
      packets--;
    end
  endtask

  task automatic send_file(input logic start);
    foreach (file_q[i]) send_byte(file_q[i], (i == 0) ? start : 1'b0);
    file_q.delete();
  endtask

  // Result side: random stall patterns, with a long hold-off whenever one is requested.
  initial begin : receiver
    int         span;
    int         mode;
    logic [7:0] mask;
    out_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(16, 160);
      mask = 8'($urandom_range(0, 255)) | 8'h01;
      for (int i = 0; i < span; i++) begin
        if (hold_off) begin
          out_if.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
          hold_off = 1'b0;
        end
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= mask[i % 8];
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL tga_rle_image_decoder");
    $finish;
  end

  initial begin : stimulus
    int          files;
    int          kind;
    int          idx;
    bit          four;
    bit          coded;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  depth;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.file_start = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The first file after reset comes without a start flag: raw 24-bit, one pixel.
    put_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_24);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h00);
    send_file(1'b0);

    // Raw 32-bit with a nonzero descriptor; bytes after the last pixel are ignored.
    put_header(TYPE_RAW, 16'd2, 16'd1, DEPTH_32);
    file_q[HDR_DEPTH + 1] = 8'hFF;
    repeat (4) put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'hA5);
    put_byte(8'h5A);
    send_file(1'b1);

    // Coded 24-bit: one literal pixel, then a full-length run cut at the image end.
    put_header(TYPE_RLE, 16'd3, 16'd2, DEPTH_24);
    put_byte(8'h00);
    put_pixels(1, 1'b0);
    put_byte(8'hFF);
    put_pixels(1, 1'b0);
    send_file(1'b1);

    // Coded 32-bit: a single-pixel run, then a long literal packet that overruns the image.
    put_header(TYPE_RLE, 16'd2, 16'd2, DEPTH_32);
    put_byte(RUN_FLAG);
    put_pixels(1, 1'b1);
    put_byte(8'h7F);
    put_pixels(4, 1'b1);
    send_file(1'b1);

    // Unsupported headers: nonzero first byte, unknown image type, nonzero last fixed byte.
    put_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_24);
    file_q[0] = 8'hFF;
    send_file(1'b1);
    put_header(8'h03, 16'd1, 16'd1, DEPTH_24);
    put_pixels(1, 1'b0);
    send_file(1'b1);
    put_header(TYPE_RLE, 16'd1, 16'd1, DEPTH_24);
    file_q[HDR_FIXED_LEN - 1] = 8'h80;
    send_file(1'b1);

    // Invalid size or depth: zero width, zero height, unsupported depths.
    put_header(TYPE_RLE, 16'd0, 16'd1, DEPTH_24);
    send_file(1'b1);
    put_header(TYPE_RAW, 16'd1, 16'd0, DEPTH_32);
    send_file(1'b1);
    put_header(TYPE_RAW, 16'd4, 16'd4, 8'd16);
    send_file(1'b1);
    put_header(TYPE_RLE, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_file(1'b1);

    // Largest image, cut short by the next file; results back up behind a long stall.
    hold_off = 1'b1;
    put_header(TYPE_RLE, 16'hFFFF, 16'hFFFF, DEPTH_32);
    put_rle_body(longint'(16'hFFFF) * 16'hFFFF, 1'b1, 10, 6);
    send_file(1'b1);

    // A restart in the middle of a header, followed by a complete file.
    put_header(TYPE_RAW, 16'd3, 16'd1, DEPTH_24);
    file_q = file_q[0:9];
    send_file(1'b1);
    put_header(TYPE_RAW, 16'd3, 16'd1, DEPTH_24);
    put_pixels(3, 1'b0);
    send_file(1'b1);
    wait_drained();

    // Random part: mostly well-formed small files, some huge truncated ones, bad headers
    // and raw noise. The byte count runs on from the files above.
    files = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      files++;
      if (files % 40 == 13) hold_off = 1'b1;
      kind  = $urandom_range(0, 19);
      four  = 1'($urandom_range(0, 1));
      coded = ($urandom_range(0, 2) != 0);
      depth = four ? DEPTH_32 : DEPTH_24;
      if (kind < 14) begin
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 4));
        put_header(coded ? TYPE_RLE : TYPE_RAW, w, h, depth);
        if (coded) put_rle_body(longint'(w) * h, four, 1000, 4);
        else put_pixels(int'(w) * int'(h), four);
        if ($urandom_range(0, 7) == 0) put_pixels(1, four);
        send_file(1'b1);
      end else if (kind < 16) begin
        w = 16'($urandom_range(1, 65535));
        h = 16'($urandom_range(1, 65535));
        put_header(coded ? TYPE_RLE : TYPE_RAW, w, h, depth);
        if (coded) put_rle_body(longint'(w) * h, four, $urandom_range(1, 5),
                                ($urandom_range(0, 3) == 0) ? MAX_PACKET : 6);
        else put_pixels($urandom_range(1, 10), four);
        send_file(1'b1);
      end else if (kind < 18) begin
        w = 16'($urandom_range(0, 65535));
        h = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       h = '0;
          2:       depth = 8'($urandom_range(0, 255));
          default: ;
        endcase
        put_header(coded ? TYPE_RLE : TYPE_RAW, w, h, depth);
        idx = $urandom_range(0, HDR_FIXED_LEN - 1);
        if (kind == 17)
          file_q[idx] = (idx == HDR_TYPE_IDX) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(1, 255));
        put_pixels($urandom_range(0, 2), four);
        send_file(1'b1);
      end else begin
        repeat ($urandom_range(1, 12))
          send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
      end
      if (files % 30 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS tga_rle_image_decoder");
    end else begin
      $display("FAIL tga_rle_image_decoder");
    end
    $finish;
  end

endmodule
